// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the two-wire master controller.
// Each macro expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/tmsc_pkg.sv =====
// Package of the two-wire master status controller.
// Holds the item function codes, register indexes, bus actions, phases and status codes.
package tmsc_pkg;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_DONE  = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      REG_ADDR    = 4'd0,
      REG_XADDR   = 4'd1,
      REG_DATA    = 4'd2,
      REG_CONTROL = 4'd3,
      REG_STATUS  = 4'd4,
      REG_CLOCK   = 4'd5,
      REG_RESET   = 4'd6,
      REG_FEATURE = 4'd7,
      REG_LINE    = 4'd8
   } reg_index_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_RESTART = 3'd2,
      ACT_SEND    = 3'd3,
      ACT_RECV    = 3'd4,
      ACT_STOP    = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ADDR  = 2'd1,
      PH_WRITE = 2'd2,
      PH_READ  = 2'd3
   } phase_type;

   localparam logic [7:0] ST_START       = 8'h08;
   localparam logic [7:0] ST_RESTART     = 8'h10;
   localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
   localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
   localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
   localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
   localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
   localparam logic [7:0] ST_IDLE        = 8'hF8;

   localparam logic [2:0] CLOCK_M_RESET = 3'd2;
   localparam logic [2:0] CLOCK_N_RESET = 3'd1;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic CSR_SEL_CLOCK_M = 1'b0;
   localparam logic CSR_SEL_CLOCK_N = 1'b1;

endpackage

// ===== hw/rtl/twi_master_status_controller.sv =====
// Two-wire bus master controller that reports numbered status codes.
// Uses tmsc_pkg and the assertion macros in assert_macros.svh.
//
// Every transfer on the request channel is a register write, a register read, a bus-done
// event or a no-op; each gives exactly one transfer on the response channel, carrying the
// read data, the status code, the interrupt line, the pending bus action and its byte.
// The controller takes one request per clock: the state and the result register are
// both loaded at the edge where the request is taken, and the only thing that holds a
// request back is a result still waiting in the single output register. The clock
// divider fields can also be written through the APB port (clock_m at byte address 0,
// clock_n at byte address 4).
`include "assert_macros.svh"

module twi_master_status_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_func,
   input  logic [3:0]                            req_reg_index,
   input  logic [7:0]                            req_write_data,
   input  logic                                  req_peer_ack,
   input  logic [7:0]                            req_peer_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [7:0]                            rsp_read_data,
   output logic [7:0]                            rsp_status_code,
   output logic                                  rsp_irq,
   output logic [2:0]                            rsp_bus_action,
   output logic [7:0]                            rsp_bus_byte,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tmsc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);

   logic [2:0]             clock_m_ff, clock_m_in;
   logic [2:0]             clock_n_ff, clock_n_in;
   logic [7:0]             status_reg_ff, status_reg_in;
   logic                   int_enable_ff, int_enable_in;
   logic                   bus_enable_ff, bus_enable_in;
   logic                   assert_ack_ff, assert_ack_in;
   logic                   int_flag_ff, int_flag_in;
   tmsc_pkg::action_type   pending_action_ff, pending_action_in;
   tmsc_pkg::phase_type    bus_phase_ff, bus_phase_in;
   logic                   bus_held_ff, bus_held_in;
   logic [7:0]             data_byte_ff, data_byte_in;
   logic [7:0]             own_address_ff, own_address_in;
   logic [7:0]             ext_address_ff, ext_address_in;
   logic [5:0]             line_control_ff, line_control_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_read_data_ff, rsp_read_data_in;
   logic [7:0]             rsp_status_code_ff;
   logic                   rsp_irq_ff;
   logic [2:0]             rsp_bus_action_ff;
   logic [7:0]             rsp_bus_byte_ff, rsp_bus_byte_in;

   logic                   req_accept;
   logic                   csr_write;
   logic                   flag_after;
   logic [7:0]             control_read;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_write  = psel && penable && pwrite;
   assign pready     = 1'b1;

   always_comb begin
      unique case (paddr[2])
         tmsc_pkg::CSR_SEL_CLOCK_M: prdata = {29'd0, clock_m_ff};
         tmsc_pkg::CSR_SEL_CLOCK_N: prdata = {29'd0, clock_n_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   assign control_read = {int_enable_ff, bus_enable_ff,
                          (pending_action_ff == tmsc_pkg::ACT_START)
                             || (pending_action_ff == tmsc_pkg::ACT_RESTART),
                          pending_action_ff == tmsc_pkg::ACT_STOP,
                          int_flag_ff, assert_ack_ff, 2'b00};

   assign flag_after = req_write_data[3] ? 1'b0 : int_flag_ff;

   always_comb begin
      clock_m_in        = clock_m_ff;
      clock_n_in        = clock_n_ff;
      status_reg_in     = status_reg_ff;
      int_enable_in     = int_enable_ff;
      bus_enable_in     = bus_enable_ff;
      assert_ack_in     = assert_ack_ff;
      int_flag_in       = int_flag_ff;
      pending_action_in = pending_action_ff;
      bus_phase_in      = bus_phase_ff;
      bus_held_in       = bus_held_ff;
      data_byte_in      = data_byte_ff;
      own_address_in    = own_address_ff;
      ext_address_in    = ext_address_ff;
      line_control_in   = line_control_ff;
      rsp_read_data_in  = 8'd0;

      if (csr_write) begin
         unique case (paddr[2])
            tmsc_pkg::CSR_SEL_CLOCK_M: clock_m_in = pwdata[2:0];
            tmsc_pkg::CSR_SEL_CLOCK_N: clock_n_in = pwdata[2:0];
            default: ;
         endcase
      end

      unique case (tmsc_pkg::func_type'(req_func))
         tmsc_pkg::FUNC_WRITE: begin
            unique case (req_reg_index)
               tmsc_pkg::REG_ADDR:  own_address_in = req_write_data;
               tmsc_pkg::REG_XADDR: ext_address_in = req_write_data;
               tmsc_pkg::REG_DATA:  data_byte_in   = req_write_data;
               tmsc_pkg::REG_CONTROL: begin
                  int_enable_in = req_write_data[7];
                  bus_enable_in = req_write_data[6];
                  assert_ack_in = req_write_data[2];
                  int_flag_in   = flag_after;
                  if (req_write_data[6] && (pending_action_ff == tmsc_pkg::ACT_NONE)
                        && !flag_after) begin
                     priority if (req_write_data[5]) begin
                        pending_action_in = bus_held_ff ? tmsc_pkg::ACT_RESTART
                                                        : tmsc_pkg::ACT_START;
                     end else if (req_write_data[4]) begin
                        pending_action_in = tmsc_pkg::ACT_STOP;
                     end else if ((bus_phase_ff == tmsc_pkg::PH_ADDR)
                                  || (bus_phase_ff == tmsc_pkg::PH_WRITE)) begin
                        pending_action_in = tmsc_pkg::ACT_SEND;
                     end else if (bus_phase_ff == tmsc_pkg::PH_READ) begin
                        pending_action_in = tmsc_pkg::ACT_RECV;
                     end else begin
                        pending_action_in = pending_action_ff;
                     end
                  end
               end
               tmsc_pkg::REG_CLOCK: begin
                  if (req_accept) begin
                     clock_m_in = req_write_data[5:3];
                     clock_n_in = req_write_data[2:0];
                  end
               end
               tmsc_pkg::REG_RESET: begin
                  if (req_write_data[0]) begin
                     status_reg_in     = tmsc_pkg::ST_IDLE;
                     int_flag_in       = 1'b0;
                     pending_action_in = tmsc_pkg::ACT_NONE;
                     bus_phase_in      = tmsc_pkg::PH_IDLE;
                     bus_held_in       = 1'b0;
                  end
               end
               tmsc_pkg::REG_LINE: line_control_in = req_write_data[5:0];
               default: ;
            endcase
         end
         tmsc_pkg::FUNC_READ: begin
            unique case (req_reg_index)
               tmsc_pkg::REG_ADDR:    rsp_read_data_in = own_address_ff;
               tmsc_pkg::REG_XADDR:   rsp_read_data_in = ext_address_ff;
               tmsc_pkg::REG_DATA:    rsp_read_data_in = data_byte_ff;
               tmsc_pkg::REG_CONTROL: rsp_read_data_in = control_read;
               tmsc_pkg::REG_STATUS:  rsp_read_data_in = status_reg_ff;
               tmsc_pkg::REG_CLOCK:   rsp_read_data_in = {2'b00, clock_m_ff, clock_n_ff};
               tmsc_pkg::REG_LINE:    rsp_read_data_in = {2'b00, line_control_ff};
               default:               rsp_read_data_in = 8'd0;
            endcase
         end
         tmsc_pkg::FUNC_DONE: begin
            unique case (pending_action_ff)
               tmsc_pkg::ACT_START, tmsc_pkg::ACT_RESTART: begin
                  status_reg_in     = bus_held_ff ? tmsc_pkg::ST_RESTART
                                                  : tmsc_pkg::ST_START;
                  bus_held_in       = 1'b1;
                  bus_phase_in      = tmsc_pkg::PH_ADDR;
                  int_flag_in       = 1'b1;
                  pending_action_in = tmsc_pkg::ACT_NONE;
               end
               tmsc_pkg::ACT_SEND: begin
                  if (bus_phase_ff == tmsc_pkg::PH_ADDR) begin
                     if (data_byte_ff[0]) begin
                        status_reg_in = req_peer_ack ? tmsc_pkg::ST_ADDR_R_ACK
                                                     : tmsc_pkg::ST_ADDR_R_NACK;
                        bus_phase_in  = tmsc_pkg::PH_READ;
                     end else begin
                        status_reg_in = req_peer_ack ? tmsc_pkg::ST_ADDR_W_ACK
                                                     : tmsc_pkg::ST_ADDR_W_NACK;
                        bus_phase_in  = tmsc_pkg::PH_WRITE;
                     end
                  end else begin
                     status_reg_in = req_peer_ack ? tmsc_pkg::ST_DATA_W_ACK
                                                  : tmsc_pkg::ST_DATA_W_NACK;
                  end
                  int_flag_in       = 1'b1;
                  pending_action_in = tmsc_pkg::ACT_NONE;
               end
               tmsc_pkg::ACT_RECV: begin
                  data_byte_in      = req_peer_byte;
                  status_reg_in     = assert_ack_ff ? tmsc_pkg::ST_DATA_R_ACK
                                                    : tmsc_pkg::ST_DATA_R_NACK;
                  int_flag_in       = 1'b1;
                  pending_action_in = tmsc_pkg::ACT_NONE;
               end
               tmsc_pkg::ACT_STOP: begin
                  status_reg_in     = tmsc_pkg::ST_IDLE;
                  bus_held_in       = 1'b0;
                  bus_phase_in      = tmsc_pkg::PH_IDLE;
                  int_flag_in       = 1'b0;
                  pending_action_in = tmsc_pkg::ACT_NONE;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign rsp_bus_byte_in = (pending_action_in == tmsc_pkg::ACT_SEND) ? data_byte_in : 8'd0;
   assign rsp_valid_in    = req_accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_m_ff        <= tmsc_pkg::CLOCK_M_RESET;
         clock_n_ff        <= tmsc_pkg::CLOCK_N_RESET;
         status_reg_ff     <= tmsc_pkg::ST_IDLE;
         int_enable_ff     <= 1'b0;
         bus_enable_ff     <= 1'b0;
         assert_ack_ff     <= 1'b0;
         int_flag_ff       <= 1'b0;
         pending_action_ff <= tmsc_pkg::ACT_NONE;
         bus_phase_ff      <= tmsc_pkg::PH_IDLE;
         bus_held_ff       <= 1'b0;
         data_byte_ff      <= 8'd0;
         own_address_ff    <= 8'd0;
         ext_address_ff    <= 8'd0;
         line_control_ff   <= 6'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         clock_m_ff   <= clock_m_in;
         clock_n_ff   <= clock_n_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            status_reg_ff     <= status_reg_in;
            int_enable_ff     <= int_enable_in;
            bus_enable_ff     <= bus_enable_in;
            assert_ack_ff     <= assert_ack_in;
            int_flag_ff       <= int_flag_in;
            pending_action_ff <= pending_action_in;
            bus_phase_ff      <= bus_phase_in;
            bus_held_ff       <= bus_held_in;
            data_byte_ff      <= data_byte_in;
            own_address_ff    <= own_address_in;
            ext_address_ff    <= ext_address_in;
            line_control_ff   <= line_control_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_read_data_ff   <= rsp_read_data_in;
         rsp_status_code_ff <= status_reg_in;
         rsp_irq_ff         <= int_enable_in && int_flag_in;
         rsp_bus_action_ff  <= pending_action_in;
         rsp_bus_byte_ff    <= rsp_bus_byte_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_status_code = rsp_status_code_ff;
   assign rsp_irq         = rsp_irq_ff;
   assign rsp_bus_action  = rsp_bus_action_ff;
   assign rsp_bus_byte    = rsp_bus_byte_ff;

   `ASSERT_ALWAYS(a_held_iff_not_idle, bus_held_ff != (bus_phase_ff == tmsc_pkg::PH_IDLE))
   `ASSERT_IMPLIES(a_send_phase, pending_action_ff == tmsc_pkg::ACT_SEND,
                   (bus_phase_ff == tmsc_pkg::PH_ADDR) || (bus_phase_ff == tmsc_pkg::PH_WRITE))
   `ASSERT_IMPLIES(a_recv_phase, pending_action_ff == tmsc_pkg::ACT_RECV,
                   bus_phase_ff == tmsc_pkg::PH_READ)
   `ASSERT_IMPLIES(a_irq_tracks_state, rsp_valid_ff,
                   rsp_irq_ff == (int_enable_ff && int_flag_ff))
   `ASSERT_IMPLIES(a_status_tracks_state, rsp_valid_ff,
                   (rsp_status_code_ff == status_reg_ff)
                   && (rsp_bus_action_ff == pending_action_ff))

endmodule

// ===== bench/tb_twi_master_status_controller.sv =====
// Self-checking testbench for the two-wire master status controller.
// Depends on tmsc_pkg and the RTL; predicts every response and checks it field by field.
// Runs directed register and bus cases, clock settings over APB, backpressure and random sessions.
module tb_twi_master_status_controller;

   localparam logic [7:0] CTL_IE   = 8'h80;
   localparam logic [7:0] CTL_EN   = 8'h40;
   localparam logic [7:0] CTL_STA  = 8'h20;
   localparam logic [7:0] CTL_STO  = 8'h10;
   localparam logic [7:0] CTL_FLAG = 8'h08;
   localparam logic [7:0] CTL_AA   = 8'h04;
   localparam int RANDOM_ITEMS = 700;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] status_code;
      logic       irq;
      logic [2:0] bus_action;
      logic [7:0] bus_byte;
   } twi_response_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_func;
   logic [3:0] req_reg_index;
   logic [7:0] req_write_data;
   logic req_peer_ack;
   logic [7:0] req_peer_byte;
   logic rsp_valid, rsp_ready;
   logic [7:0] rsp_read_data, rsp_status_code, rsp_bus_byte;
   logic rsp_irq;
   logic [2:0] rsp_bus_action;
   logic psel, penable, pwrite, pready;
   logic [tmsc_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;

   twi_response_type pending_responses[$];
   twi_response_type seen_response;
   int errors = 0;
   int sent_items = 0;
   int hold_off_cycles = 0;
   bit calm = 0;

   // Shadow copy of the controller state.
   logic [2:0] shadow_clock_m, shadow_clock_n;
   logic [7:0] shadow_status;
   logic shadow_int_en, shadow_bus_en, shadow_assert_ack, shadow_int_flag, shadow_bus_held;
   tmsc_pkg::action_type shadow_action;
   tmsc_pkg::phase_type shadow_phase;
   logic [7:0] shadow_data, shadow_own_addr, shadow_ext_addr;
   logic [5:0] shadow_line;

   twi_master_status_controller uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_reg_index(req_reg_index),
      .req_write_data(req_write_data), .req_peer_ack(req_peer_ack),
      .req_peer_byte(req_peer_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data), .rsp_status_code(rsp_status_code),
      .rsp_irq(rsp_irq), .rsp_bus_action(rsp_bus_action), .rsp_bus_byte(rsp_bus_byte),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void reset_bus_logic();
      shadow_status = tmsc_pkg::ST_IDLE;
      shadow_int_flag = 1'b0;
      shadow_action = tmsc_pkg::ACT_NONE;
      shadow_phase = tmsc_pkg::PH_IDLE;
      shadow_bus_held = 1'b0;
   endfunction

   // Applies one request to the shadow state and returns the response it must produce.
   function automatic twi_response_type controller_step(logic [1:0] f, logic [3:0] idx,
                                                        logic [7:0] wd, logic ack,
                                                        logic [7:0] pb);
      twi_response_type r;
      r.read_data = 8'h00;
      case (f)
         tmsc_pkg::FUNC_WRITE: begin
            case (idx)
               tmsc_pkg::REG_ADDR: shadow_own_addr = wd;
               tmsc_pkg::REG_XADDR: shadow_ext_addr = wd;
               tmsc_pkg::REG_DATA: shadow_data = wd;
               tmsc_pkg::REG_CONTROL: begin
                  shadow_int_en = wd[7];
                  shadow_bus_en = wd[6];
                  shadow_assert_ack = wd[2];
                  if ((wd & CTL_FLAG) != 0) shadow_int_flag = 1'b0;
                  if (shadow_bus_en && shadow_action == tmsc_pkg::ACT_NONE
                        && !shadow_int_flag) begin
                     if ((wd & CTL_STA) != 0)
                        shadow_action = shadow_bus_held ? tmsc_pkg::ACT_RESTART
                                                        : tmsc_pkg::ACT_START;
                     else if ((wd & CTL_STO) != 0)
                        shadow_action = tmsc_pkg::ACT_STOP;
                     else if (shadow_phase == tmsc_pkg::PH_ADDR
                              || shadow_phase == tmsc_pkg::PH_WRITE)
                        shadow_action = tmsc_pkg::ACT_SEND;
                     else if (shadow_phase == tmsc_pkg::PH_READ)
                        shadow_action = tmsc_pkg::ACT_RECV;
                  end
               end
               tmsc_pkg::REG_CLOCK: begin
                  shadow_clock_m = wd[5:3];
                  shadow_clock_n = wd[2:0];
               end
               tmsc_pkg::REG_RESET: if (wd[0]) reset_bus_logic();
               tmsc_pkg::REG_LINE: shadow_line = wd[5:0];
               default: ;
            endcase
         end
         tmsc_pkg::FUNC_READ: begin
            case (idx)
               tmsc_pkg::REG_ADDR: r.read_data = shadow_own_addr;
               tmsc_pkg::REG_XADDR: r.read_data = shadow_ext_addr;
               tmsc_pkg::REG_DATA: r.read_data = shadow_data;
               tmsc_pkg::REG_CONTROL: r.read_data = {shadow_int_en, shadow_bus_en,
                  shadow_action == tmsc_pkg::ACT_START || shadow_action == tmsc_pkg::ACT_RESTART,
                  shadow_action == tmsc_pkg::ACT_STOP, shadow_int_flag, shadow_assert_ack,
                  2'b00};
               tmsc_pkg::REG_STATUS: r.read_data = shadow_status;
               tmsc_pkg::REG_CLOCK: r.read_data = {2'b00, shadow_clock_m, shadow_clock_n};
               tmsc_pkg::REG_LINE: r.read_data = {2'b00, shadow_line};
               default: r.read_data = 8'h00;
            endcase
         end
         tmsc_pkg::FUNC_DONE: begin
            case (shadow_action)
               tmsc_pkg::ACT_START, tmsc_pkg::ACT_RESTART: begin
                  shadow_status = shadow_bus_held ? tmsc_pkg::ST_RESTART : tmsc_pkg::ST_START;
                  shadow_bus_held = 1'b1;
                  shadow_phase = tmsc_pkg::PH_ADDR;
                  shadow_int_flag = 1'b1;
               end
               tmsc_pkg::ACT_SEND: begin
                  if (shadow_phase == tmsc_pkg::PH_ADDR) begin
                     if (shadow_data[0]) begin
                        shadow_status = ack ? tmsc_pkg::ST_ADDR_R_ACK : tmsc_pkg::ST_ADDR_R_NACK;
                        shadow_phase = tmsc_pkg::PH_READ;
                     end else begin
                        shadow_status = ack ? tmsc_pkg::ST_ADDR_W_ACK : tmsc_pkg::ST_ADDR_W_NACK;
                        shadow_phase = tmsc_pkg::PH_WRITE;
                     end
                  end else begin
                     shadow_status = ack ? tmsc_pkg::ST_DATA_W_ACK : tmsc_pkg::ST_DATA_W_NACK;
                  end
                  shadow_int_flag = 1'b1;
               end
               tmsc_pkg::ACT_RECV: begin
                  shadow_data = pb;
                  shadow_status = shadow_assert_ack ? tmsc_pkg::ST_DATA_R_ACK
                                                    : tmsc_pkg::ST_DATA_R_NACK;
                  shadow_int_flag = 1'b1;
               end
               tmsc_pkg::ACT_STOP: begin
                  shadow_status = tmsc_pkg::ST_IDLE;
                  shadow_bus_held = 1'b0;
                  shadow_phase = tmsc_pkg::PH_IDLE;
                  shadow_int_flag = 1'b0;
               end
               default: ;
            endcase
            shadow_action = tmsc_pkg::ACT_NONE;
         end
         default: ;
      endcase
      r.status_code = shadow_status;
      r.irq = shadow_int_en & shadow_int_flag;
      r.bus_action = shadow_action;
      r.bus_byte = (shadow_action == tmsc_pkg::ACT_SEND) ? shadow_data : 8'h00;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            $display("%0t: response transfer with nothing expected, expected none, actual %h",
                     $time, rsp_status_code);
            errors++;
         end else begin
            seen_response = pending_responses.pop_front();
            check_field("read_data", seen_response.read_data, rsp_read_data);
            check_field("status_code", seen_response.status_code, rsp_status_code);
            check_field("irq", {7'd0, seen_response.irq}, {7'd0, rsp_irq});
            check_field("bus_action", {5'd0, seen_response.bus_action}, {5'd0, rsp_bus_action});
            check_field("bus_byte", seen_response.bus_byte, rsp_bus_byte);
         end
      end
   end

   // Response side: random stalls, or a counted hold-off when one is requested.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         rsp_ready <= calm || $urandom_range(99) >= 16;
      end
   end

   task automatic send_request(input logic [1:0] f, input logic [3:0] idx,
                               input logic [7:0] wd, input logic ack, input logic [7:0] pb);
      if (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_func <= f;
      req_reg_index <= idx;
      req_write_data <= wd;
      req_peer_ack <= ack;
      req_peer_byte <= pb;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_responses.push_back(controller_step(f, idx, wd, ack, pb));
      sent_items++;
   endtask

   task automatic reg_write(input logic [3:0] idx, input logic [7:0] v);
      send_request(tmsc_pkg::FUNC_WRITE, idx, v, 1'($urandom_range(1)), 8'($urandom));
   endtask

   task automatic reg_read(input logic [3:0] idx);
      send_request(tmsc_pkg::FUNC_READ, idx, 8'($urandom), 1'($urandom_range(1)),
                   8'($urandom));
   endtask

   task automatic bus_event(input logic ack, input logic [7:0] pb);
      send_request(tmsc_pkg::FUNC_DONE, 4'($urandom_range(15)), 8'($urandom), ack, pb);
   endtask

   task automatic random_request();
      send_request(2'($urandom_range(3)), 4'($urandom_range(15)), 8'($urandom),
                   1'($urandom_range(1)), 8'($urandom));
   endtask

   task automatic maybe_noise();
      if ($urandom_range(99) < 12) random_request();
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic sel, input logic [2:0] value);
      logic [31:0] word;
      word = $urandom;
      word[2:0] = value;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (sel == tmsc_pkg::CSR_SEL_CLOCK_M) shadow_clock_m = value;
      else shadow_clock_n = value;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== {29'd0, value}) begin
         $display("%0t: prdata mismatch, expected %h, actual %h", $time, {29'd0, value},
                  prdata);
         errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // One bus transaction: start, address byte, a few data bytes, maybe a restart, stop.
   task automatic bus_session();
      logic [7:0] base;
      logic reading;
      int restarts;
      int k;
      base = CTL_EN | ($urandom_range(1) ? CTL_IE : 8'h00);
      restarts = ($urandom_range(3) == 0) ? 1 : 0;
      for (k = 0; k <= restarts; k++) begin
         reg_write(tmsc_pkg::REG_CONTROL,
                   base | CTL_FLAG | CTL_STA | ($urandom_range(3) == 0 ? CTL_STO : 8'h00));
         maybe_noise();
         bus_event(1'($urandom_range(1)), 8'($urandom));
         reading = 1'($urandom_range(1));
         reg_write(tmsc_pkg::REG_DATA, {7'($urandom_range(127)), reading});
         reg_write(tmsc_pkg::REG_CONTROL, base | CTL_FLAG);
         bus_event(1'($urandom_range(1)), 8'($urandom));
         repeat ($urandom_range(1, 4)) begin
            if (reading) begin
               reg_write(tmsc_pkg::REG_CONTROL,
                         base | CTL_FLAG | ($urandom_range(1) ? CTL_AA : 8'h00));
            end else begin
               if ($urandom_range(1)) reg_write(tmsc_pkg::REG_DATA, 8'($urandom));
               reg_write(tmsc_pkg::REG_CONTROL, base | CTL_FLAG);
            end
            maybe_noise();
            bus_event(1'($urandom_range(1)), 8'($urandom));
            if ($urandom_range(3) == 0)
               reg_read($urandom_range(1) ? tmsc_pkg::REG_STATUS : tmsc_pkg::REG_DATA);
         end
      end
      reg_write(tmsc_pkg::REG_CONTROL, base | CTL_FLAG | CTL_STO);
      maybe_noise();
      bus_event(1'($urandom_range(1)), 8'($urandom));
   endtask

   task automatic test_register_file();
      reg_write(tmsc_pkg::REG_ADDR, 8'hFF);
      reg_read(tmsc_pkg::REG_ADDR);
      reg_write(tmsc_pkg::REG_LINE, 8'hFF);
      reg_read(tmsc_pkg::REG_LINE);
      reg_write(tmsc_pkg::REG_STATUS, 8'h00);
      reg_write(tmsc_pkg::REG_FEATURE, 8'hFF);
      reg_read(tmsc_pkg::REG_FEATURE);
      send_request(tmsc_pkg::FUNC_WRITE, 4'hF, 8'hFF, 1'b1, 8'hFF);
      send_request(tmsc_pkg::FUNC_READ, 4'hF, 8'h00, 1'b0, 8'h00);
      send_request(tmsc_pkg::FUNC_NOP, tmsc_pkg::REG_CONTROL, 8'hFF, 1'b1, 8'hFF);
      bus_event(1'b1, 8'hFF);
      reg_write(tmsc_pkg::REG_CLOCK, 8'hFF);
      reg_read(tmsc_pkg::REG_CLOCK);
   endtask

   task automatic test_bus_sequence();
      // Start and stop together: start wins.
      reg_write(tmsc_pkg::REG_CONTROL, CTL_IE | CTL_EN | CTL_STA | CTL_STO);
      reg_read(tmsc_pkg::REG_CONTROL);
      bus_event(1'b1, 8'h00);
      reg_write(tmsc_pkg::REG_DATA, 8'hA0);
      reg_write(tmsc_pkg::REG_CONTROL, CTL_IE | CTL_EN | CTL_FLAG);
      bus_event(1'b1, 8'h00);
      reg_write(tmsc_pkg::REG_CONTROL, CTL_IE | CTL_EN | CTL_FLAG);
      bus_event(1'b0, 8'h00);
      reg_write(tmsc_pkg::REG_CONTROL, CTL_IE | CTL_EN | CTL_FLAG | CTL_STA);
      bus_event(1'b1, 8'h00);
      reg_write(tmsc_pkg::REG_DATA, 8'h01);
      reg_write(tmsc_pkg::REG_CONTROL, CTL_IE | CTL_EN | CTL_FLAG);
      bus_event(1'b0, 8'h00);
      reg_write(tmsc_pkg::REG_CONTROL, CTL_EN | CTL_FLAG);
      bus_event(1'b1, 8'hFF);
      reg_write(tmsc_pkg::REG_CONTROL, CTL_EN | CTL_FLAG | CTL_STO);
      bus_event(1'b0, 8'h00);
      reg_write(tmsc_pkg::REG_RESET, 8'h01);
   endtask

   task automatic test_backpressure();
      calm = 1;
      hold_off_cycles = 50;
      repeat (24) random_request();
      calm = 0;
      wait_all_responses();
   endtask

   task automatic test_clock_settings();
      logic [2:0] m_values[5];
      logic [2:0] n_values[5];
      int k;
      m_values = '{3'd0, 3'd7, 3'd0, 3'd7, 3'($urandom_range(7))};
      n_values = '{3'd0, 3'd7, 3'd7, 3'd0, 3'($urandom_range(7))};
      for (k = 0; k < 5; k++) begin
         wait_all_responses();
         csr_write(tmsc_pkg::CSR_SEL_CLOCK_M, m_values[k]);
         csr_write(tmsc_pkg::CSR_SEL_CLOCK_N, n_values[k]);
         reg_read(tmsc_pkg::REG_CLOCK);
         bus_session();
      end
   endtask

   task automatic test_random_sessions();
      int start_count;
      start_count = sent_items;
      while (sent_items - start_count < RANDOM_ITEMS) begin
         calm = (sent_items - start_count >= 300) && (sent_items - start_count < 450);
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6)) random_request();
         end else begin
            bus_session();
         end
      end
      calm = 0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= tmsc_pkg::FUNC_NOP;
      req_reg_index <= tmsc_pkg::REG_ADDR;
      req_write_data <= 8'h00;
      req_peer_ack <= 1'b0;
      req_peer_byte <= 8'h00;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= 32'd0;
      shadow_clock_m = tmsc_pkg::CLOCK_M_RESET;
      shadow_clock_n = tmsc_pkg::CLOCK_N_RESET;
      shadow_int_en = 1'b0;
      shadow_bus_en = 1'b0;
      shadow_assert_ack = 1'b0;
      shadow_data = 8'h00;
      shadow_own_addr = 8'h00;
      shadow_ext_addr = 8'h00;
      shadow_line = 6'd0;
      reset_bus_logic();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_register_file();
      test_bus_sequence();
      test_backpressure();
      test_clock_settings();
      test_random_sessions();
      wait_all_responses();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tmsc_pkg.sv
hw/rtl/twi_master_status_controller.sv
bench/tb_twi_master_status_controller.sv
